FILE: design/nrsh_pkg.sv
// ----------------------------------------------------------------------------
// nrsh_pkg: shared types and constants for the nearest ray segment hit block
// Coordinate widths, stored edge layout, and micro-op control for the shared
// multiply/accumulate unit.
// ----------------------------------------------------------------------------
`default_nettype none

package nrsh_pkg;

    localparam int CW    = 24;   // coordinate width, Q19.4
    localparam int DW    = 25;   // coordinate difference width
    localparam int MW    = 26;   // multiplier operand width
    localparam int PW    = 52;   // multiplier product width
    localparam int XW    = 51;   // cross product width
    localparam int MAGW  = 50;   // cross product magnitude width
    localparam int HW    = 25;   // half of a magnitude
    localparam int AW_AC = 102;  // accumulator width
    localparam int QW    = 25;   // quotient width
    localparam int CNTW  = 7;    // edge_count register width
    localparam int IDXW  = 6;    // edge_index width

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_CAST = 1'b1;

    typedef logic signed [CW-1:0] coord_t;

    typedef struct packed {
        coord_t x0;
        coord_t y0;
        coord_t x1;
        coord_t y1;
    } edge_t;

    typedef enum logic [1:0] {
        SH_0,
        SH_H,
        SH_HH
    } shift_t;

    typedef enum logic [1:0] {
        LAT_NONE,
        LAT_DEN,
        LAT_TN,
        LAT_UN
    } latch_t;

    typedef struct packed {
        logic   clr;
        logic   sub;
        shift_t sh;
        latch_t lat;
    } mac_ctrl_t;

    function automatic logic signed [MW-1:0] lo_half(input logic [MAGW-1:0] v);
        return $signed({1'b0, v[HW-1:0]});
    endfunction

    function automatic logic signed [MW-1:0] hi_half(input logic [MAGW-1:0] v);
        return $signed({1'b0, v[MAGW-1:HW]});
    endfunction

    function automatic logic signed [DW-1:0] sub_c(input coord_t a, input coord_t b);
        return $signed({a[CW-1], a}) - $signed({b[CW-1], b});
    endfunction

endpackage

`default_nettype wire

FILE: design/nearest_ray_segment_hit.sv
// ----------------------------------------------------------------------------
// nearest_ray_segment_hit: nearest intersection of a ray segment with walls
// Stores wall edges, then for a cast searches the first edge_count stored edges with exact
// cross product tests and reports the nearest point a + trunc(t * r).
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  in      | input     | in_valid / in_ready   | cmd, edge_index, p0_x, p0_y, p1_x, p1_y
//  out     | output    | out_valid / out_ready | hit, hit_x, hit_y
//  cfg     | input     | cfg_valid / cfg_ready | cfg_data (edge_count)
//
//  A load is written to the edge store when accepted. A cast tests each stored edge in turn,
//  compares a hitting edge with the hit already held, then divides out the hit point.
//  All products go through one 26x26 multiplier; the hit point uses a 25-step divider.
//  Reset clears control and edge_count; the edge store is not cleared.
//  A stalled result is held while the next item is accepted; a cast then waits at the end.
`default_nettype none

module nearest_ray_segment_hit #(
    parameter int MAX_EDGES = 64
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          in_valid,
    output logic                         in_ready,
    input  wire                          cmd,
    input  wire  [nrsh_pkg::IDXW-1:0]    edge_index,
    input  wire  signed [nrsh_pkg::CW-1:0] p0_x,
    input  wire  signed [nrsh_pkg::CW-1:0] p0_y,
    input  wire  signed [nrsh_pkg::CW-1:0] p1_x,
    input  wire  signed [nrsh_pkg::CW-1:0] p1_y,
    output logic                         out_valid,
    input  wire                          out_ready,
    output logic                         hit,
    output logic signed [nrsh_pkg::CW-1:0] hit_x,
    output logic signed [nrsh_pkg::CW-1:0] hit_y,
    input  wire                          cfg_valid,
    output logic                         cfg_ready,
    input  wire  [nrsh_pkg::CNTW-1:0]    cfg_data
);
    import nrsh_pkg::*;

    localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int KW = $clog2(MAX_EDGES + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_DIFF,
        S_MUL,
        S_DRAIN,
        S_TEST,
        S_DIV,
        S_FIX,
        S_OUT
    } state_t;

    typedef enum logic [1:0] {
        PH_CROSS,
        PH_CMP,
        PH_OFF
    } phase_t;

    edge_t                 mem [MAX_EDGES];
    edge_t                 rd_reg;

    state_t                state_reg;
    phase_t                phase_reg;
    logic [2:0]            step_reg;
    logic [KW-1:0]         k_reg;
    logic [KW-1:0]         n_reg;
    logic [CNTW-1:0]       edge_count_reg;
    coord_t                ax_reg, ay_reg;
    logic signed [DW-1:0]  rx_reg, ry_reg;
    logic signed [DW-1:0]  ssx_reg, ssy_reg, cx_reg, cy_reg;
    logic signed [XW-1:0]  den_reg, tn_reg, un_reg;
    logic signed [AW_AC-1:0] acc_reg;
    logic signed [PW-1:0]  prod_reg;
    logic                  pend_valid_reg;
    mac_ctrl_t             pend_reg;
    logic                  found_reg;
    logic [MAGW-1:0]       best_n_reg, best_d_reg, cand_n_reg, cand_d_reg;
    logic [XW-1:0]         rem_reg;
    logic [HW-1:0]         low_reg;
    logic [QW-1:0]         q_reg;
    logic [4:0]            div_cnt_reg;
    logic                  sel_y_reg;
    coord_t                hx_reg, hy_reg;
    logic                  out_valid_reg;
    logic                  hit_reg;
    coord_t                hit_x_reg, hit_y_reg;

    logic signed [MW-1:0]  mul_a, mul_b;
    mac_ctrl_t             ctrl;
    logic [2:0]            last_step;
    logic signed [PW-1:0]  prod;
    logic signed [AW_AC-1:0] term, base, acc_next;
    logic signed [DW-1:0]  rsel;
    logic [DW-1:0]         mag;
    logic                  den_neg;
    logic signed [XW-1:0]  dn, tnn, unn;
    logic                  pass;
    logic [XW:0]           rem2;
    logic                  ge;
    logic signed [CW+1:0]  off_w, coord_w;
    logic                  load_we;
    logic                  in_xfer;

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign hit_x     = hit_x_reg;
    assign hit_y     = hit_y_reg;
    assign in_xfer   = in_valid && in_ready;
    assign load_we   = in_xfer && (cmd == CMD_LOAD) && (32'(edge_index) < MAX_EDGES);

    always_comb
    begin
        rsel = sel_y_reg ? ry_reg : rx_reg;
        mag  = rsel[DW-1] ? DW'(-rsel) : DW'(rsel);
    end

    always_comb
    begin
        mul_a     = '0;
        mul_b     = '0;
        ctrl      = '{clr: 1'b0, sub: 1'b0, sh: SH_0, lat: LAT_NONE};
        last_step = 3'd0;
        unique case (phase_reg)
            PH_CROSS:
            begin
                last_step = 3'd5;
                unique case (step_reg)
                    3'd0:
                    begin
                        mul_a = MW'(rx_reg); mul_b = MW'(ssy_reg); ctrl.clr = 1'b1;
                    end
                    3'd1:
                    begin
                        mul_a = MW'(ry_reg); mul_b = MW'(ssx_reg);
                        ctrl.sub = 1'b1; ctrl.lat = LAT_DEN;
                    end
                    3'd2:
                    begin
                        mul_a = MW'(cx_reg); mul_b = MW'(ssy_reg); ctrl.clr = 1'b1;
                    end
                    3'd3:
                    begin
                        mul_a = MW'(cy_reg); mul_b = MW'(ssx_reg);
                        ctrl.sub = 1'b1; ctrl.lat = LAT_TN;
                    end
                    3'd4:
                    begin
                        mul_a = MW'(cx_reg); mul_b = MW'(ry_reg); ctrl.clr = 1'b1;
                    end
                    3'd5:
                    begin
                        mul_a = MW'(cy_reg); mul_b = MW'(rx_reg);
                        ctrl.sub = 1'b1; ctrl.lat = LAT_UN;
                    end
                    default:
                    begin
                        mul_a = '0;
                    end
                endcase
            end
            PH_CMP:
            begin
                last_step = 3'd7;
                unique case (step_reg)
                    3'd0:
                    begin
                        mul_a = lo_half(cand_n_reg); mul_b = lo_half(best_d_reg);
                        ctrl.clr = 1'b1;
                    end
                    3'd1:
                    begin
                        mul_a = lo_half(cand_n_reg); mul_b = hi_half(best_d_reg);
                        ctrl.sh = SH_H;
                    end
                    3'd2:
                    begin
                        mul_a = hi_half(cand_n_reg); mul_b = lo_half(best_d_reg);
                        ctrl.sh = SH_H;
                    end
                    3'd3:
                    begin
                        mul_a = hi_half(cand_n_reg); mul_b = hi_half(best_d_reg);
                        ctrl.sh = SH_HH;
                    end
                    3'd4:
                    begin
                        mul_a = lo_half(best_n_reg); mul_b = lo_half(cand_d_reg);
                        ctrl.sub = 1'b1;
                    end
                    3'd5:
                    begin
                        mul_a = lo_half(best_n_reg); mul_b = hi_half(cand_d_reg);
                        ctrl.sub = 1'b1; ctrl.sh = SH_H;
                    end
                    3'd6:
                    begin
                        mul_a = hi_half(best_n_reg); mul_b = lo_half(cand_d_reg);
                        ctrl.sub = 1'b1; ctrl.sh = SH_H;
                    end
                    default:
                    begin
                        mul_a = hi_half(best_n_reg); mul_b = hi_half(cand_d_reg);
                        ctrl.sub = 1'b1; ctrl.sh = SH_HH;
                    end
                endcase
            end
            PH_OFF:
            begin
                last_step = 3'd1;
                mul_b     = $signed({1'b0, mag});
                if (step_reg == 3'd0)
                begin
                    mul_a = lo_half(best_n_reg); ctrl.clr = 1'b1;
                end
                else
                begin
                    mul_a = hi_half(best_n_reg); ctrl.sh = SH_H;
                end
            end
            default:
            begin
                last_step = 3'd0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    always_comb
    begin
        term = AW_AC'(prod_reg);
        unique case (pend_reg.sh)
            SH_H:    term = term <<< HW;
            SH_HH:   term = term <<< (2 * HW);
            default: term = term;
        endcase
        base     = pend_reg.clr ? '0 : acc_reg;
        acc_next = pend_reg.sub ? (base - term) : (base + term);
    end

    always_comb
    begin
        den_neg = den_reg[XW-1];
        dn      = den_neg ? -den_reg : den_reg;
        tnn     = den_neg ? -tn_reg  : tn_reg;
        unn     = den_neg ? -un_reg  : un_reg;
        pass    = (den_reg != '0) && (tnn >= 0) && (tnn <= dn) && (unn >= 0) && (unn <= dn);
        rem2    = {rem_reg, low_reg[HW-1]};
        ge      = rem2 >= {2'b00, best_d_reg};
        off_w   = rsel[DW-1] ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});
        coord_w = $signed({{2{(sel_y_reg ? ay_reg[CW-1] : ax_reg[CW-1])}},
                           (sel_y_reg ? ay_reg : ax_reg)}) + off_w;
    end

    always_ff @(posedge clk)
    begin
        if (load_we)
        begin
            mem[AW'(edge_index)] <= '{x0: p0_x, y0: p0_y, x1: p1_x, y1: p1_y};
        end
        if (state_reg == S_RD)
        begin
            rd_reg <= mem[k_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            phase_reg      <= PH_CROSS;
            step_reg       <= '0;
            k_reg          <= '0;
            n_reg          <= '0;
            edge_count_reg <= '0;
            ax_reg         <= '0;
            ay_reg         <= '0;
            rx_reg         <= '0;
            ry_reg         <= '0;
            ssx_reg        <= '0;
            ssy_reg        <= '0;
            cx_reg         <= '0;
            cy_reg         <= '0;
            den_reg        <= '0;
            tn_reg         <= '0;
            un_reg         <= '0;
            acc_reg        <= '0;
            prod_reg       <= '0;
            pend_valid_reg <= 1'b0;
            pend_reg       <= '{clr: 1'b0, sub: 1'b0, sh: SH_0, lat: LAT_NONE};
            found_reg      <= 1'b0;
            best_n_reg     <= '0;
            best_d_reg     <= '0;
            cand_n_reg     <= '0;
            cand_d_reg     <= '0;
            rem_reg        <= '0;
            low_reg        <= '0;
            q_reg          <= '0;
            div_cnt_reg    <= '0;
            sel_y_reg      <= 1'b0;
            hx_reg         <= '0;
            hy_reg         <= '0;
            out_valid_reg  <= 1'b0;
            hit_reg        <= 1'b0;
            hit_x_reg      <= '0;
            hit_y_reg      <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                edge_count_reg <= cfg_data;
            end

            if (out_valid_reg && out_ready && (state_reg != S_OUT))
            begin
                out_valid_reg <= 1'b0;
            end

            prod_reg       <= prod;
            pend_reg       <= ctrl;
            pend_valid_reg <= (state_reg == S_MUL);

            if (pend_valid_reg)
            begin
                acc_reg <= acc_next;
                unique case (pend_reg.lat)
                    LAT_DEN: den_reg <= acc_next[XW-1:0];
                    LAT_TN:  tn_reg  <= acc_next[XW-1:0];
                    LAT_UN:  un_reg  <= acc_next[XW-1:0];
                    default: ;
                endcase
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer && (cmd == CMD_CAST))
                    begin
                        ax_reg    <= p0_x;
                        ay_reg    <= p0_y;
                        rx_reg    <= sub_c(p1_x, p0_x);
                        ry_reg    <= sub_c(p1_y, p0_y);
                        k_reg     <= '0;
                        found_reg <= 1'b0;
                        sel_y_reg <= 1'b0;
                        n_reg     <= (32'(edge_count_reg) > MAX_EDGES) ? KW'(MAX_EDGES)
                                                                        : KW'(edge_count_reg);
                        state_reg <= S_RD;
                    end
                end
                S_RD:
                begin
                    step_reg <= '0;
                    if (k_reg == n_reg)
                    begin
                        phase_reg <= PH_OFF;
                        state_reg <= found_reg ? S_MUL : S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_DIFF;
                    end
                end
                S_DIFF:
                begin
                    ssx_reg   <= sub_c(rd_reg.x1, rd_reg.x0);
                    ssy_reg   <= sub_c(rd_reg.y1, rd_reg.y0);
                    cx_reg    <= sub_c(rd_reg.x0, ax_reg);
                    cy_reg    <= sub_c(rd_reg.y0, ay_reg);
                    phase_reg <= PH_CROSS;
                    step_reg  <= '0;
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    if (step_reg == last_step)
                    begin
                        step_reg  <= '0;
                        state_reg <= S_DRAIN;
                    end
                    else
                    begin
                        step_reg <= step_reg + 3'd1;
                    end
                end
                S_DRAIN:
                begin
                    unique case (phase_reg)
                        PH_CROSS:
                        begin
                            state_reg <= S_TEST;
                        end
                        PH_CMP:
                        begin
                            if (acc_next < 0)
                            begin
                                best_n_reg <= cand_n_reg;
                                best_d_reg <= cand_d_reg;
                            end
                            k_reg     <= k_reg + KW'(1);
                            state_reg <= S_RD;
                        end
                        default:
                        begin
                            rem_reg     <= acc_next[HW+XW-1:HW];
                            low_reg     <= acc_next[HW-1:0];
                            div_cnt_reg <= '0;
                            state_reg   <= S_DIV;
                        end
                    endcase
                end
                S_TEST:
                begin
                    if (pass && found_reg)
                    begin
                        cand_n_reg <= tnn[MAGW-1:0];
                        cand_d_reg <= dn[MAGW-1:0];
                        phase_reg  <= PH_CMP;
                        step_reg   <= '0;
                        state_reg  <= S_MUL;
                    end
                    else
                    begin
                        if (pass)
                        begin
                            found_reg  <= 1'b1;
                            best_n_reg <= tnn[MAGW-1:0];
                            best_d_reg <= dn[MAGW-1:0];
                        end
                        k_reg     <= k_reg + KW'(1);
                        state_reg <= S_RD;
                    end
                end
                S_DIV:
                begin
                    rem_reg     <= ge ? XW'(rem2 - {2'b00, best_d_reg}) : rem2[XW-1:0];
                    q_reg       <= {q_reg[QW-2:0], ge};
                    low_reg     <= {low_reg[HW-2:0], 1'b0};
                    div_cnt_reg <= div_cnt_reg + 5'd1;
                    if (div_cnt_reg == 5'(QW - 1))
                    begin
                        state_reg <= S_FIX;
                    end
                end
                S_FIX:
                begin
                    step_reg <= '0;
                    if (!sel_y_reg)
                    begin
                        hx_reg    <= coord_w[CW-1:0];
                        sel_y_reg <= 1'b1;
                        phase_reg <= PH_OFF;
                        state_reg <= S_MUL;
                    end
                    else
                    begin
                        hy_reg    <= coord_w[CW-1:0];
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        hit_reg       <= found_reg;
                        hit_x_reg     <= found_reg ? hx_reg : '0;
                        hit_y_reg     <= found_reg ? hy_reg : '0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_best_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg |-> (best_n_reg <= best_d_reg) && (best_d_reg != '0))
        else $error("best hit fraction out of range");

    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (rem_reg < {1'b0, best_d_reg}))
        else $error("divider remainder not below divisor");

    a_miss_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !hit_reg) |-> (hit_x_reg == '0) && (hit_y_reg == '0))
        else $error("miss result carries a point");

    a_edge_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (k_reg <= n_reg))
        else $error("edge counter past search limit");

endmodule

`default_nettype wire
